// ----- rtl/oaht_pkg.sv -----
// ----------------------------------------------------------------------------
// oaht_pkg
// Types and codes shared by the open-addressing hash table modules.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int TAG_W   = 2;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;
  localparam int CFG_W   = 4;

  localparam logic [CFG_W-1:0] CAP_LOG2_RESET = 4'd8;
  localparam logic [CFG_W-1:0] CAP_LOG2_MIN   = 4'd2;

  localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

  localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
  localparam logic [TAG_W-1:0] TAG_USED  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_DEAD  = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic tag_we;
    logic key_we;
    logic val_we;
  } store_ctl_t;

endpackage

// ----- rtl/oaht_store.sv -----
// ----------------------------------------------------------------------------
// oaht_store
// Slot tag, key and value memories: one write and one registered read port.
// ----------------------------------------------------------------------------
module oaht_store #(
  parameter int CAPACITY = 256,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  oaht_pkg::store_ctl_t       ctl,
  input  logic [IDX_W-1:0]           rd_addr,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [oaht_pkg::TAG_W-1:0] wr_tag,
  input  logic [oaht_pkg::KEY_W-1:0] wr_key,
  input  logic [oaht_pkg::VAL_W-1:0] wr_val,
  output logic [oaht_pkg::TAG_W-1:0] rd_tag,
  output logic [oaht_pkg::KEY_W-1:0] rd_key,
  output logic [oaht_pkg::VAL_W-1:0] rd_val
);

  logic [oaht_pkg::TAG_W-1:0] tag_mem [CAPACITY];
  logic [oaht_pkg::KEY_W-1:0] key_mem [CAPACITY];
  logic [oaht_pkg::VAL_W-1:0] val_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (ctl.tag_we) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    if (ctl.rd_en) begin
      rd_tag <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (ctl.rd_en) begin
      rd_key <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (ctl.rd_en) begin
      rd_val <= val_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/oaht_seq.sv -----
// ----------------------------------------------------------------------------
// oaht_seq
// Probe sequencer: one slot compared per cycle, stop handling, count and
// result register.
// ----------------------------------------------------------------------------
module oaht_seq #(
  parameter int CAPACITY = 256,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = IDX_W + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [oaht_pkg::CFG_W-1:0]   cap_log2,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [oaht_pkg::CMD_W-1:0]   in_cmd,
  input  logic [oaht_pkg::KEY_W-1:0]   in_key,
  input  logic [31:0]                  in_hash,
  input  logic [oaht_pkg::VAL_W-1:0]   in_val,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [oaht_pkg::STAT_W-1:0]  out_status,
  output logic [oaht_pkg::VAL_W-1:0]   out_val,
  output logic [oaht_pkg::SLOT_W-1:0]  out_slot,
  output logic [oaht_pkg::COUNT_W-1:0] out_count,
  output oaht_pkg::store_ctl_t         st_ctl,
  output logic [IDX_W-1:0]             st_rd_addr,
  output logic [IDX_W-1:0]             st_wr_addr,
  output logic [oaht_pkg::TAG_W-1:0]   st_wr_tag,
  output logic [oaht_pkg::KEY_W-1:0]   st_wr_key,
  output logic [oaht_pkg::VAL_W-1:0]   st_wr_val,
  input  logic [oaht_pkg::TAG_W-1:0]   st_rd_tag,
  input  logic [oaht_pkg::KEY_W-1:0]   st_rd_key,
  input  logic [oaht_pkg::VAL_W-1:0]   st_rd_val
);

  oaht_pkg::state_t state_r, state_nxt;

  logic [oaht_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [oaht_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [oaht_pkg::VAL_W-1:0]   val_r, val_nxt;
  logic [IDX_W-1:0]             start_r, start_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [IDX_W-1:0]             clr_r, clr_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [oaht_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [oaht_pkg::VAL_W-1:0]   res_val_r, res_val_nxt;
  logic [IDX_W-1:0]             res_slot_r, res_slot_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [oaht_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [oaht_pkg::VAL_W-1:0]   out_val_r, out_val_nxt;
  logic [oaht_pkg::SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [oaht_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic [oaht_pkg::CFG_W-1:0] lg;
  logic [CNT_W-1:0]           size;
  logic [IDX_W-1:0]           mask;
  logic [IDX_W-1:0]           in_start;
  logic [IDX_W-1:0]           next_idx;
  logic                       accept;
  logic                       clr_done;
  logic                       hit;
  logic                       stop;
  logic                       wrap;
  logic                       is_used;
  logic                       out_free;
  logic [31:0]                slot_ext;
  logic [31:0]                cnt_ext;

  // active table size and index mask
  assign lg   = (cap_log2 < oaht_pkg::CAP_LOG2_MIN) ? oaht_pkg::CAP_LOG2_MIN : cap_log2;
  assign size = ({1'b0, lg} >= 5'(IDX_W)) ? CNT_W'(CAPACITY) : (CNT_W'(1) << lg);
  assign mask = IDX_W'(size - CNT_W'(1));

  assign in_start = in_hash[IDX_W-1:0] & mask;
  assign next_idx = (idx_r + IDX_W'(1)) & mask;
  assign accept   = (state_r == oaht_pkg::S_IDLE) && in_valid;
  assign clr_done = (clr_r == IDX_W'(CAPACITY - 1));
  assign is_used  = (st_rd_tag == oaht_pkg::TAG_USED);
  assign hit      = is_used && (st_rd_key == key_r);
  assign stop     = hit || (st_rd_tag == oaht_pkg::TAG_EMPTY) ||
                    ((cmd_r == oaht_pkg::CMD_SET) && (st_rd_tag == oaht_pkg::TAG_DEAD));
  assign wrap     = (next_idx == start_r);
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oaht_pkg::S_CLEAR: begin
        if (clr_done) state_nxt = oaht_pkg::S_IDLE;
      end
      oaht_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == oaht_pkg::CMD_SET || in_cmd == oaht_pkg::CMD_GET ||
                       in_cmd == oaht_pkg::CMD_DEL) ? oaht_pkg::S_PROBE : oaht_pkg::S_HOLD;
        end
      end
      oaht_pkg::S_PROBE: begin
        if (stop || wrap) state_nxt = oaht_pkg::S_HOLD;
      end
      oaht_pkg::S_HOLD: begin
        if (out_free) state_nxt = oaht_pkg::S_IDLE;
      end
      default: state_nxt = oaht_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    st_ctl         = '0;
    st_rd_addr     = next_idx;
    st_wr_addr     = idx_r;
    st_wr_tag      = oaht_pkg::TAG_USED;
    st_wr_key      = key_r;
    st_wr_val      = val_r;
    in_ready       = 1'b0;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    start_nxt      = start_r;
    idx_nxt        = idx_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    slot_ext       = 32'(res_slot_r);
    cnt_ext        = 32'(cnt_r);

    case (state_r)
      oaht_pkg::S_CLEAR: begin
        st_ctl.tag_we = 1'b1;
        st_wr_addr    = clr_r;
        st_wr_tag     = oaht_pkg::TAG_EMPTY;
        clr_nxt       = clr_r + IDX_W'(1);
      end
      oaht_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        st_ctl.rd_en = in_valid;
        st_rd_addr   = in_start;
        if (accept) begin
          cmd_nxt        = in_cmd;
          key_nxt        = in_key;
          val_nxt        = in_val;
          start_nxt      = in_start;
          idx_nxt        = in_start;
          res_status_nxt = oaht_pkg::ST_OK;
          res_val_nxt    = '0;
          res_slot_nxt   = '0;
        end
      end
      oaht_pkg::S_PROBE: begin
        if (stop) begin
          res_slot_nxt = idx_r;
          case (cmd_r)
            oaht_pkg::CMD_SET: begin
              st_ctl.val_we = 1'b1;
              if (!is_used) begin
                st_ctl.tag_we = 1'b1;
                st_ctl.key_we = 1'b1;
                if (cnt_r < size) cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            oaht_pkg::CMD_GET: begin
              if (is_used) res_val_nxt = st_rd_val;
              else res_status_nxt = oaht_pkg::ST_NOTFOUND;
            end
            default: begin
              if (is_used) begin
                st_ctl.tag_we = 1'b1;
                st_wr_tag     = oaht_pkg::TAG_DEAD;
                if (cnt_r != '0) cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
          endcase
        end else if (wrap) begin
          res_status_nxt = oaht_pkg::ST_FULL;
        end else begin
          st_ctl.rd_en = 1'b1;
          idx_nxt      = next_idx;
        end
      end
      oaht_pkg::S_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_val_nxt    = res_val_r;
          out_slot_nxt   = slot_ext[oaht_pkg::SLOT_W-1:0];
          out_count_nxt  = cnt_ext[oaht_pkg::COUNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oaht_pkg::S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    start_r      <= start_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_val    = out_val_r;
  assign out_slot   = out_slot_r;
  assign out_count  = out_count_r;

endmodule

// ----- rtl/open_addressing_hash_table.sv -----
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Linear-probing hash table with tombstones; set, get and delete by key.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per operation; in_tuser holds the command, in_tdata the
//           key, the caller's hash and the value.
//   out_* : one result word per operation; out_tuser holds the status,
//           out_tdata the value read, the stop slot and the entry count.
//   cfg_* : writes capacity_log2; write only while no operation is in flight.
// Timing: a probe checks one slot per cycle through the single read port of
//   the slot memories. An operation that stops at the k-th slot shows its
//   result in the cycle in which in_tready returns; k runs from 1 to the
//   table size, so load sets the rate. An unused command skips the probe
//   and returns status OK with a zero value and slot.
// Reset: a clearing pass marks every slot empty, with in_tready low; cfg
//   writes are taken throughout.
// Stall: the result sits in the output register until taken; the next
//   operation may be accepted and probed meanwhile, and waits only to
//   hand over its own result.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // key[31:0], key_hash[63:32], value[95:64]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // value_out[31:0], slot_index[39:32], entry_count[48:40]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data    // capacity_log2[3:0]
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic [oaht_pkg::CFG_W-1:0]   cap_log2_r, cap_log2_nxt;
  oaht_pkg::store_ctl_t         st_ctl;
  logic [IDX_W-1:0]             st_rd_addr;
  logic [IDX_W-1:0]             st_wr_addr;
  logic [oaht_pkg::TAG_W-1:0]   st_wr_tag;
  logic [oaht_pkg::KEY_W-1:0]   st_wr_key;
  logic [oaht_pkg::VAL_W-1:0]   st_wr_val;
  logic [oaht_pkg::TAG_W-1:0]   st_rd_tag;
  logic [oaht_pkg::KEY_W-1:0]   st_rd_key;
  logic [oaht_pkg::VAL_W-1:0]   st_rd_val;
  logic [oaht_pkg::STAT_W-1:0]  out_status;
  logic [oaht_pkg::VAL_W-1:0]   out_val;
  logic [oaht_pkg::SLOT_W-1:0]  out_slot;
  logic [oaht_pkg::COUNT_W-1:0] out_count;

  assign cfg_ready    = 1'b1;
  assign cap_log2_nxt = cfg_valid ? cfg_data : cap_log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_log2_r <= oaht_pkg::CAP_LOG2_RESET;
    end else begin
      cap_log2_r <= cap_log2_nxt;
    end
  end

  oaht_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap_log2   (cap_log2_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_key     (in_tdata[31:0]),
    .in_hash    (in_tdata[63:32]),
    .in_val     (in_tdata[95:64]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_val    (out_val),
    .out_slot   (out_slot),
    .out_count  (out_count),
    .st_ctl     (st_ctl),
    .st_rd_addr (st_rd_addr),
    .st_wr_addr (st_wr_addr),
    .st_wr_tag  (st_wr_tag),
    .st_wr_key  (st_wr_key),
    .st_wr_val  (st_wr_val),
    .st_rd_tag  (st_rd_tag),
    .st_rd_key  (st_rd_key),
    .st_rd_val  (st_rd_val)
  );

  oaht_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .ctl     (st_ctl),
    .rd_addr (st_rd_addr),
    .wr_addr (st_wr_addr),
    .wr_tag  (st_wr_tag),
    .wr_key  (st_wr_key),
    .wr_val  (st_wr_val),
    .rd_tag  (st_rd_tag),
    .rd_key  (st_rd_key),
    .rd_val  (st_rd_val)
  );

  assign out_tuser = out_status;
  assign out_tdata = {7'd0, out_count, out_slot, out_val};

endmodule
